// File: rtl/core/sliding_median_deviation_cost_assert.svh
// assertion macros for the sliding median deviation cost block
// used by the top level only, no other dependencies
`ifndef SLIDING_MEDIAN_DEVIATION_COST_ASSERT_SVH
`define SLIDING_MEDIAN_DEVIATION_COST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SMDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/smdc_pkg.sv
// shared constants and types for the sliding median deviation cost block
// no dependencies
package smdc_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 6;
  localparam int WINDOW_RESET    = 8;

  typedef struct packed {
    logic ins;
    logic del;
    logic dev;
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MED,
    ST_DEV,
    ST_SUM
  } state_t;

endpackage

// File: rtl/core/smdc_cell.sv
// one slot of the sorted window: value, age and absolute deviation
// depends on smdc_pkg
module smdc_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_BITS    = 5
) (
  input  logic                          clk,
  input  smdc_pkg::cell_op_t            op,
  input  logic                          occ,
  input  logic                          at_fill,
  input  logic signed [SAMPLE_BITS-1:0] new_val,
  input  logic signed [SAMPLE_BITS-1:0] med_val,
  input  logic [AGE_BITS-1:0]           del_age,
  input  logic                          left_gt,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic [AGE_BITS-1:0]           left_age,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic [AGE_BITS-1:0]           right_age,
  input  logic                          shift_in,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic [AGE_BITS-1:0]           age,
  output logic                          gt,
  output logic                          shift_out,
  output logic [SAMPLE_BITS-1:0]        dev
);
  import smdc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic [AGE_BITS-1:0]           age_r;
  logic [SAMPLE_BITS-1:0]        dev_r;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          diff_abs;
  logic                          hit;

  always_comb begin
    gt        = occ && (val_r > new_val);
    hit       = occ && (age_r == del_age);
    shift_out = shift_in | hit;
    diff      = {val_r[SAMPLE_BITS-1], val_r} - {med_val[SAMPLE_BITS-1], med_val};
    diff_abs  = diff[SAMPLE_BITS] ? (-diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (left_gt) begin
        val_r <= left_val;
        age_r <= left_age + AGE_BITS'(1);
      end else if (gt || at_fill) begin
        val_r <= new_val;
        age_r <= '0;
      end else begin
        age_r <= age_r + AGE_BITS'(1);
      end
    end else if (op.del && shift_out) begin
      val_r <= right_val;
      age_r <= right_age;
    end
    if (op.dev) begin
      dev_r <= occ ? diff_abs[SAMPLE_BITS-1:0] : '0;
    end
  end

  assign val = val_r;
  assign age = age_r;
  assign dev = dev_r;

endmodule

// File: rtl/core/smdc_sum_tree.sv
// registered binary adder tree summing the per-slot deviations
// depends on smdc_pkg
module smdc_sum_tree #(
  parameter int LEAVES   = 32,
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 21
) (
  input  logic                clk,
  input  logic [IN_BITS-1:0]  leaf [LEAVES],
  output logic [OUT_BITS-1:0] sum
);
  import smdc_pkg::*;

  localparam int LEVELS = $clog2(LEAVES);
  localparam int P      = 1 << LEVELS;

  logic [OUT_BITS-1:0] ext [P];

  for (genvar i = 0; i < P; i++) begin : g_ext
    if (i < LEAVES) begin : g_used
      assign ext[i] = OUT_BITS'(leaf[i]);
    end else begin : g_pad
      assign ext[i] = '0;
    end
  end

  if (LEVELS == 0) begin : g_flat
    assign sum = ext[0];
  end else begin : g_tree
    logic [OUT_BITS-1:0] node_r [1:P-1];
    for (genvar n = 1; n < P; n++) begin : g_node
      logic [OUT_BITS-1:0] lhs;
      logic [OUT_BITS-1:0] rhs;
      if (2 * n >= P) begin : g_leafs
        assign lhs = ext[2*n-P];
        assign rhs = ext[2*n+1-P];
      end else begin : g_inner
        assign lhs = node_r[2*n];
        assign rhs = node_r[2*n+1];
      end
      always_ff @(posedge clk) begin
        node_r[n] <= lhs + rhs;
      end
    end
    assign sum = node_r[1];
  end

endmodule

// File: rtl/core/sliding_median_deviation_cost.sv
// sliding window median and absolute deviation sum, top level
// depends on smdc_pkg, smdc_cell, smdc_sum_tree and the assertion header
//
// samples arrive on in_valid/in_stall with in_sample_value; results leave on
// out_valid/out_stall with out_median_value and out_deviation_cost. a transfer
// happens on a clock edge with valid high and stall low.
// cfg_wr_en with cfg_window_size sets the window length (0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW) and empties the window.
// a sample that does not complete the window is inserted and gives no
// result. a sample that completes it goes through insert, median pick,
// deviation capture and oldest removal, then the registered adder tree.
// in_stall stays high during that time and in any cycle with cfg_wr_en high.
// the result sits in an output register; a stall on the result side holds it
// and the next sample is still taken, but a new result waits until the
// register is free.
// reset (rst_n low, synchronous) empties the window, sets the length to 8
// (or MAX_WINDOW if smaller) and drops any pending result.
module sliding_median_deviation_cost #(
  parameter int MAX_WINDOW  = smdc_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = smdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_wr_en,
  input  logic [smdc_pkg::CFG_BITS-1:0]                  cfg_window_size,
  input  logic                                           in_valid,
  output logic                                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]                  in_sample_value,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]                  out_median_value,
  output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]      out_deviation_cost
);
  import smdc_pkg::*;

  localparam int LEVELS    = $clog2(MAX_WINDOW);
  localparam int COST_BITS = SAMPLE_BITS + LEVELS;
  localparam int SIZE_BITS = $clog2(MAX_WINDOW + 1);
  localparam int AGE_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_BITS  = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
  localparam int RESET_EFF = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  state_t                        state_r, state_nxt;
  logic [SIZE_BITS-1:0]          eff_r, eff_nxt;
  logic [SIZE_BITS-1:0]          fill_r, fill_nxt;
  logic [CNT_BITS-1:0]           cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] med_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_med_r;
  logic [COST_BITS-1:0]          out_cost_r;

  cell_op_t                      op;
  logic                          accept;
  logic                          fills;
  logic                          cnt_done;
  logic                          out_load;
  logic [AGE_BITS-1:0]           del_age;
  logic [AGE_BITS-1:0]           med_idx;
  logic [COST_BITS-1:0]          cost_sum;

  logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
  logic [AGE_BITS-1:0]           cell_age [MAX_WINDOW];
  logic                          cell_gt  [MAX_WINDOW];
  logic                          cell_sh  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]        cell_dev [MAX_WINDOW];

  assign accept   = in_valid && !in_stall;
  assign fills    = (fill_r + SIZE_BITS'(1)) == eff_r;
  assign cnt_done = cnt_r == CNT_BITS'(LEVELS);
  assign del_age  = AGE_BITS'(eff_r - SIZE_BITS'(1));
  assign med_idx  = AGE_BITS'((eff_r - SIZE_BITS'(1)) >> 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !cfg_wr_en && fills) state_nxt = ST_MED;
      end
      ST_MED:  state_nxt = ST_DEV;
      ST_DEV:  state_nxt = ST_SUM;
      ST_SUM: begin
        if (cnt_done && (!out_valid_r || !out_stall)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    op       = '0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = cfg_wr_en;
        op.ins   = accept && !cfg_wr_en;
      end
      ST_MED: ;
      ST_DEV: begin
        op.del = 1'b1;
        op.dev = 1'b1;
      end
      ST_SUM:  out_load = cnt_done && (!out_valid_r || !out_stall);
      default: ;
    endcase
  end

  always_comb begin
    eff_nxt  = eff_r;
    fill_nxt = fill_r;
    if (cfg_wr_en) begin
      fill_nxt = '0;
      if (cfg_window_size == '0) begin
        eff_nxt = SIZE_BITS'(1);
      end else if (32'(cfg_window_size) > 32'(MAX_WINDOW)) begin
        eff_nxt = SIZE_BITS'(MAX_WINDOW);
      end else begin
        eff_nxt = SIZE_BITS'(cfg_window_size);
      end
    end else if (op.ins) begin
      fill_nxt = fill_r + SIZE_BITS'(1);
    end else if (op.del && fill_r != '0) begin
      fill_nxt = fill_r - SIZE_BITS'(1);
    end
    cnt_nxt = '0;
    if (state_r == ST_SUM) cnt_nxt = cnt_done ? cnt_r : cnt_r + CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eff_r       <= SIZE_BITS'(RESET_EFF);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eff_r   <= eff_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MED) begin
      med_r <= cell_val[med_idx];
    end
    if (out_load) begin
      out_med_r  <= med_r;
      out_cost_r <= cost_sum;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          left_gt;
    logic signed [SAMPLE_BITS-1:0] left_val;
    logic [AGE_BITS-1:0]           left_age;
    logic signed [SAMPLE_BITS-1:0] right_val;
    logic [AGE_BITS-1:0]           right_age;
    logic                          shift_in;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = in_sample_value;
      assign left_age = '0;
      assign shift_in = 1'b0;
    end else begin : g_mid
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
      assign left_age = cell_age[i-1];
      assign shift_in = cell_sh[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_val = cell_val[i];
      assign right_age = cell_age[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
      assign right_age = cell_age[i+1];
    end

    smdc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_BITS   (AGE_BITS)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .occ      (fill_r > SIZE_BITS'(i)),
      .at_fill  (fill_r == SIZE_BITS'(i)),
      .new_val  (in_sample_value),
      .med_val  (med_r),
      .del_age  (del_age),
      .left_gt  (left_gt),
      .left_val (left_val),
      .left_age (left_age),
      .right_val(right_val),
      .right_age(right_age),
      .shift_in (shift_in),
      .val      (cell_val[i]),
      .age      (cell_age[i]),
      .gt       (cell_gt[i]),
      .shift_out(cell_sh[i]),
      .dev      (cell_dev[i])
    );
  end

  smdc_sum_tree #(
    .LEAVES  (MAX_WINDOW),
    .IN_BITS (SAMPLE_BITS),
    .OUT_BITS(COST_BITS)
  ) u_sum_tree (
    .clk (clk),
    .leaf(cell_dev),
    .sum (cost_sum)
  );

  assign out_valid          = out_valid_r;
  assign out_median_value   = out_med_r;
  assign out_deviation_cost = out_cost_r;

`include "sliding_median_deviation_cost_assert.svh"

  `SMDC_ASSERT_NOW(a_fill_below_size, clk, rst_n,
    (state_r == ST_IDLE || state_r == ST_SUM), (fill_r < eff_r),
    "window holds too many samples")
  `SMDC_ASSERT_NOW(a_full_at_median, clk, rst_n,
    (state_r == ST_MED), (fill_r == eff_r),
    "median picked from a window that is not full")
  `SMDC_ASSERT_NEXT(a_result_once, clk, rst_n,
    (out_valid && !out_stall && state_r != ST_SUM), (!out_valid),
    "result repeated after transfer")

endmodule
